FILE: rtl/prime_test_sum_count_top_k_top_assert.svh
// assertion macros for the prime tester, clocked on clk_i, off in reset
`ifndef PRIME_TEST_SUM_COUNT_TOP_K_TOP_ASSERT_SVH
`define PRIME_TEST_SUM_COUNT_TOP_K_TOP_ASSERT_SVH

`define PTSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PTSC_ASSERT_IMPLY(label, ante, cons, msg) \
  `PTSC_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/ptsc_pkg.sv
package ptsc_pkg;

  localparam int VALUE_BITS = 27;
  localparam int KEEP_COUNT = 10;
  localparam int COUNT_BITS = 27;
  localparam int SUM_BITS   = 48;
  localparam int KEEP_BITS  = $clog2(KEEP_COUNT + 1);
  localparam int IDX_BITS   = $clog2(KEEP_COUNT);
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * DIV_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  localparam logic CMD_TEST   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_DIV    = 6'b000100,
    S_UPDATE = 6'b001000,
    S_EMIT   = 6'b010000,
    S_REPORT = 6'b100000
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

FILE: rtl/ptsc_div.sv
module ptsc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ptsc_pkg::div_ctrl_t                 ctrl_i,
  input  logic [ptsc_pkg::VALUE_BITS-1:0]     number_i,
  input  logic [ptsc_pkg::DIV_BITS-1:0]       divisor_i,
  output ptsc_pkg::div_stat_t                 stat_o
);

  logic [ptsc_pkg::VALUE_BITS-1:0] num_q, num_d;
  logic [ptsc_pkg::DIV_BITS-1:0]   rem_q, rem_d;
  logic [ptsc_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [ptsc_pkg::DIV_BITS:0]     trial;
  logic [ptsc_pkg::DIV_BITS:0]     diff;

  // one quotient bit per cycle, msb first
  assign trial = {rem_q, num_q[ptsc_pkg::VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      num_d  = number_i;
      rem_d  = '0;
      cnt_d  = ptsc_pkg::CNT_BITS'(ptsc_pkg::VALUE_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[ptsc_pkg::VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[ptsc_pkg::DIV_BITS-1:0];
      end else begin
        rem_d = trial[ptsc_pkg::DIV_BITS-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/prime_test_sum_count_top_k_top.sv
// channel | signals                                   | direction
// in      | in_valid_i in_ready_o command_i number_i   | into block
// out     | out_valid_o out_ready_i is_prime_o          | out of block
//         | prime_count_o prime_sum_o top_prime_o       |
//         | top_valid_o last_o                          |
// a test of an odd number runs the bit-serial remainder unit once per odd divisor
// even numbers and numbers below 3 skip that unit, a report gives one item
// per cycle while the output register is free or out_ready_i is high
// one item is in work at a time; a new item is taken while a result waits
// reset clears the totals and the kept list length, list entries are not cleared
// results wait in an output register while out_ready_i is low
module prime_test_sum_count_top_k_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [ptsc_pkg::VALUE_BITS-1:0]   number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_prime_o,
  output logic [ptsc_pkg::COUNT_BITS-1:0]   prime_count_o,
  output logic [ptsc_pkg::SUM_BITS-1:0]     prime_sum_o,
  output logic [ptsc_pkg::VALUE_BITS-1:0]   top_prime_o,
  output logic                              top_valid_o,
  output logic                              last_o
);

  ptsc_pkg::state_e                  state_q, state_d;
  logic [ptsc_pkg::VALUE_BITS-1:0]   num_q, num_d;
  logic [ptsc_pkg::DIV_BITS-1:0]     div_q, div_d;
  logic [ptsc_pkg::SQ_BITS-1:0]      sq_q, sq_d;
  logic                              prime_q, prime_d;
  logic [ptsc_pkg::COUNT_BITS-1:0]   count_q, count_d;
  logic [ptsc_pkg::SUM_BITS-1:0]     sum_q, sum_d;
  logic [ptsc_pkg::KEEP_BITS-1:0]    kept_q, kept_d;
  logic [ptsc_pkg::IDX_BITS-1:0]     idx_q, idx_d;
  logic [ptsc_pkg::VALUE_BITS-1:0]   list_q [ptsc_pkg::KEEP_COUNT];
  logic [ptsc_pkg::VALUE_BITS-1:0]   list_new [ptsc_pkg::KEEP_COUNT];
  logic [ptsc_pkg::KEEP_COUNT-1:0]   ge;
  logic                              list_we;
  logic [ptsc_pkg::SUM_BITS:0]       sum_add;

  logic                              out_valid_q, out_valid_d;
  logic                              out_load;
  logic                              out_free;
  logic                              o_prime_d, o_tvalid_d, o_last_d;
  logic [ptsc_pkg::VALUE_BITS-1:0]   o_top_d;
  logic                              o_prime_q, o_tvalid_q, o_last_q;
  logic [ptsc_pkg::VALUE_BITS-1:0]   o_top_q;
  logic [ptsc_pkg::COUNT_BITS-1:0]   o_count_q;
  logic [ptsc_pkg::SUM_BITS-1:0]     o_sum_q;

  ptsc_pkg::div_ctrl_t               div_ctrl;
  ptsc_pkg::div_stat_t               div_stat;
  logic                              in_acc;
  logic                              last_rpt;

  ptsc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .number_i  (num_q),
    .divisor_i (div_q),
    .stat_o    (div_stat)
  );

  assign in_ready_o = (state_q == ptsc_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign sum_add    = {1'b0, sum_q} + ptsc_pkg::SUM_BITS'(num_q);
  assign last_rpt   = (kept_q == '0) ||
                      (ptsc_pkg::KEEP_BITS'(idx_q) == kept_q - 1'b1);

  // sorted insert, entries at or above the new prime stay in place
  always_comb begin
    for (int i = 0; i < ptsc_pkg::KEEP_COUNT; i++) begin
      ge[i] = (ptsc_pkg::KEEP_BITS'(i) < kept_q) && (list_q[i] >= num_q);
    end
    for (int i = 0; i < ptsc_pkg::KEEP_COUNT; i++) begin
      if (ge[i]) begin
        list_new[i] = list_q[i];
      end else if (i == 0) begin
        list_new[i] = num_q;
      end else if (ge[i-1]) begin
        list_new[i] = num_q;
      end else begin
        list_new[i] = list_q[i-1];
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    num_d         = num_q;
    div_d         = div_q;
    sq_d          = sq_q;
    prime_d       = prime_q;
    count_d       = count_q;
    sum_d         = sum_q;
    kept_d        = kept_q;
    idx_d         = idx_q;
    list_we       = 1'b0;
    div_ctrl      = '0;
    out_load      = 1'b0;
    o_prime_d     = 1'b0;
    o_top_d       = '0;
    o_tvalid_d    = 1'b0;
    o_last_d      = 1'b1;
    unique case (state_q)
      ptsc_pkg::S_IDLE: begin
        if (in_acc) begin
          num_d = number_i;
          div_d = ptsc_pkg::DIV_BITS'(3);
          sq_d  = ptsc_pkg::SQ_BITS'(9);
          idx_d = '0;
          if (command_i == ptsc_pkg::CMD_REPORT) begin
            state_d = ptsc_pkg::S_REPORT;
          end else if (number_i < ptsc_pkg::VALUE_BITS'(2)) begin
            prime_d = 1'b0;
            state_d = ptsc_pkg::S_UPDATE;
          end else if (number_i == ptsc_pkg::VALUE_BITS'(2)) begin
            prime_d = 1'b1;
            state_d = ptsc_pkg::S_UPDATE;
          end else if (!number_i[0]) begin
            prime_d = 1'b0;
            state_d = ptsc_pkg::S_UPDATE;
          end else begin
            prime_d = 1'b1;
            state_d = ptsc_pkg::S_CHECK;
          end
        end
      end
      ptsc_pkg::S_CHECK: begin
        if (sq_q <= ptsc_pkg::SQ_BITS'(num_q)) begin
          div_ctrl.start = 1'b1;
          state_d        = ptsc_pkg::S_DIV;
        end else begin
          state_d = ptsc_pkg::S_UPDATE;
        end
      end
      ptsc_pkg::S_DIV: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            prime_d = 1'b0;
            state_d = ptsc_pkg::S_UPDATE;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            div_d   = div_q + ptsc_pkg::DIV_BITS'(2);
            sq_d    = sq_q + ptsc_pkg::SQ_BITS'({div_q, 2'b00}) + ptsc_pkg::SQ_BITS'(4);
            state_d = ptsc_pkg::S_CHECK;
          end
        end
      end
      ptsc_pkg::S_UPDATE: begin
        if (prime_q) begin
          if (count_q != ptsc_pkg::COUNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          if (sum_add[ptsc_pkg::SUM_BITS]) begin
            sum_d = ptsc_pkg::SUM_MAX;
          end else begin
            sum_d = sum_add[ptsc_pkg::SUM_BITS-1:0];
          end
          list_we = 1'b1;
          if (kept_q != ptsc_pkg::KEEP_BITS'(ptsc_pkg::KEEP_COUNT)) begin
            kept_d = kept_q + 1'b1;
          end
        end
        state_d = ptsc_pkg::S_EMIT;
      end
      ptsc_pkg::S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_prime_d = prime_q;
          state_d   = ptsc_pkg::S_IDLE;
        end
      end
      ptsc_pkg::S_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_last_d = last_rpt;
          if (kept_q != '0) begin
            o_top_d    = list_q[idx_q];
            o_tvalid_d = 1'b1;
          end
          if (last_rpt) begin
            state_d = ptsc_pkg::S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ptsc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptsc_pkg::S_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      kept_q      <= '0;
      idx_q       <= '0;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      kept_q      <= kept_d;
      idx_q       <= idx_d;
      prime_q     <= prime_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    sq_q  <= sq_d;
    if (list_we) begin
      for (int i = 0; i < ptsc_pkg::KEEP_COUNT; i++) begin
        list_q[i] <= list_new[i];
      end
    end
    if (out_load) begin
      o_prime_q  <= o_prime_d;
      o_count_q  <= count_q;
      o_sum_q    <= sum_q;
      o_top_q    <= o_top_d;
      o_tvalid_q <= o_tvalid_d;
      o_last_q   <= o_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = o_prime_q;
  assign prime_count_o = o_count_q;
  assign prime_sum_o   = o_sum_q;
  assign top_prime_o   = o_top_q;
  assign top_valid_o   = o_tvalid_q;
  assign last_o        = o_last_q;

endmodule

FILE: rtl/ptsc_chk.sv
`include "prime_test_sum_count_top_k_top_assert.svh"

module ptsc_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              is_prime_o,
  input logic [ptsc_pkg::VALUE_BITS-1:0]   top_prime_o,
  input logic                              top_valid_o,
  input logic                              last_o
);

  `PTSC_ASSERT_IMPLY(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o, "out item dropped")
  `PTSC_ASSERT_IMPLY(a_one_item, in_valid_i && in_ready_o, ##1 !in_ready_o, "second item taken")
  `PTSC_ASSERT_IMPLY(a_prime_item, out_valid_o && is_prime_o, last_o && !top_valid_o, "bad test item")
  `PTSC_ASSERT_IMPLY(a_empty_top, out_valid_o && !top_valid_o, last_o && top_prime_o == '0, "bad empty item")

endmodule

bind prime_test_sum_count_top_k_top ptsc_chk u_ptsc_chk (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ptsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 100;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                  cmd;
    logic [VALUE_BITS-1:0] num;
  } number_item_t;

  typedef struct packed {
    logic                  is_prime;
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   sum;
    logic [VALUE_BITS-1:0] top;
    logic                  top_valid;
    logic                  last_flag;
  } prime_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  logic                  command;
  logic [VALUE_BITS-1:0] number;
  logic                  out_valid;
  logic                  out_ready;
  logic                  is_prime;
  logic [COUNT_BITS-1:0] prime_count;
  logic [SUM_BITS-1:0]   prime_sum;
  logic [VALUE_BITS-1:0] top_prime;
  logic                  top_valid;
  logic                  last_flag;

  number_item_t  number_queue[$];
  prime_result_t due_results[$];

  logic [COUNT_BITS-1:0] primes_found;
  logic [SUM_BITS-1:0]   primes_total;
  logic [VALUE_BITS-1:0] largest_kept[KEEP_COUNT];
  int                    kept_count;

  logic in_taken;
  int   items_sent;
  int   results_seen;
  int   error_count;
  int   idle_cycles;

  prime_test_sum_count_top_k_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .number_i      (number),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .is_prime_o    (is_prime),
    .prime_count_o (prime_count),
    .prime_sum_o   (prime_sum),
    .top_prime_o   (top_prime),
    .top_valid_o   (top_valid),
    .last_o        (last_flag)
  );

  function automatic bit trial_divide(input logic [VALUE_BITS-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    if (v == 2) return 1'b1;
    if ((v & 1) == 0) return 1'b0;
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic keep_largest(input logic [VALUE_BITS-1:0] p);
    int pos;
    if (kept_count >= KEEP_COUNT) begin
      if (p <= largest_kept[KEEP_COUNT-1]) return;
      pos = KEEP_COUNT - 1;
    end else begin
      pos = kept_count;
      kept_count++;
    end
    while (pos > 0 && largest_kept[pos-1] < p) begin
      largest_kept[pos] = largest_kept[pos-1];
      pos--;
    end
    largest_kept[pos] = p;
  endtask

  task automatic tally_command(input logic cmd, input logic [VALUE_BITS-1:0] num);
    prime_result_t r;
    logic [SUM_BITS-1:0] wide;
    bit prime;
    r = '0;
    if (cmd == CMD_TEST) begin
      prime = trial_divide(num);
      if (prime) begin
        wide = SUM_BITS'(num);
        if (primes_found != COUNT_MAX) primes_found++;
        if (primes_total > SUM_MAX - wide) primes_total = SUM_MAX;
        else primes_total = primes_total + wide;
        keep_largest(num);
      end
      r.is_prime  = prime;
      r.count     = primes_found;
      r.sum       = primes_total;
      r.last_flag = 1'b1;
      due_results.push_back(r);
    end else if (kept_count == 0) begin
      r.count     = primes_found;
      r.sum       = primes_total;
      r.last_flag = 1'b1;
      due_results.push_back(r);
    end else begin
      for (int i = 0; i < kept_count; i++) begin
        r.count     = primes_found;
        r.sum       = primes_total;
        r.top       = largest_kept[i];
        r.top_valid = 1'b1;
        r.last_flag = (i + 1 == kept_count);
        due_results.push_back(r);
      end
    end
  endtask

  task automatic queue_test(input logic [VALUE_BITS-1:0] n);
    number_item_t it;
    it.cmd = CMD_TEST;
    it.num = n;
    number_queue.push_back(it);
  endtask

  task automatic queue_report();
    number_item_t it;
    it.cmd = CMD_REPORT;
    it.num = VALUE_BITS'($urandom);
    number_queue.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin : drive_inputs
    number_item_t next_item;
    bit gap;
    gap = !(items_sent >= 40 && items_sent < 80) && ($urandom_range(0, 99) < 7);
    if (rst_ni && (!in_valid || in_taken)) begin
      if (number_queue.size() > 0 && !gap) begin
        next_item = number_queue.pop_front();
        items_sent++;
        in_valid <= 1'b1;
        command  <= next_item.cmd;
        number   <= next_item.num;
      end else begin
        in_valid <= 1'b0;
      end
    end
    gap = !(results_seen >= 50 && results_seen < 110) && ($urandom_range(0, 99) < 7);
    out_ready <= !gap;
  end

  // monitor and checker
  always @(posedge clk_i) begin : check_outputs
    prime_result_t got;
    prime_result_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) tally_command(command, number);
      if (out_valid && out_ready) begin
        got.is_prime  = is_prime;
        got.count     = prime_count;
        got.sum       = prime_sum;
        got.top       = top_prime;
        got.top_valid = top_valid;
        got.last_flag = last_flag;
        results_seen++;
        if (due_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected item: prime=%0b count=%0d sum=%0d top=%0d top_valid=%0b last=%0b",
                     got.is_prime, got.count, got.sum, got.top, got.top_valid, got.last_flag);
        end else begin
          want = due_results.pop_front();
          if (got != want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("mismatch on item %0d", results_seen);
              $display("  expected prime=%0b count=%0d sum=%0d top=%0d top_valid=%0b last=%0b",
                       want.is_prime, want.count, want.sum, want.top, want.top_valid,
                       want.last_flag);
              $display("  actual   prime=%0b count=%0d sum=%0d top=%0d top_valid=%0b last=%0b",
                       got.is_prime, got.count, got.sum, got.top, got.top_valid,
                       got.last_flag);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int pick;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    command      = CMD_TEST;
    number       = '0;
    out_ready    = 1'b0;
    in_taken     = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    error_count  = 0;
    idle_cycles  = 0;
    primes_found = '0;
    primes_total = '0;
    kept_count   = 0;
    foreach (largest_kept[i]) largest_kept[i] = '0;

    // directed: empty report, edge values, squares, filling and overflowing the kept list
    queue_report();
    queue_test(0);
    queue_test(1);
    queue_test(2);
    queue_test(3);
    queue_test(4);
    queue_test(9);
    queue_test(25);
    queue_report();
    queue_test('1);
    queue_test(134217689);
    queue_test(67092481);
    queue_test(3);
    queue_test(5);
    queue_test(7);
    queue_test(11);
    queue_test(13);
    queue_test(17);
    queue_test(19);
    queue_test(2);
    queue_test(23);
    queue_report();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) queue_report();
      else if (pick < 16) queue_test(VALUE_BITS'($urandom));
      else if (pick < 46) queue_test(VALUE_BITS'($urandom_range(0, 65535)));
      else if (pick < 76) queue_test(VALUE_BITS'($urandom_range(0, 1023) | 1));
      else queue_test(VALUE_BITS'($urandom_range(0, 1023)));
    end
    queue_report();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (number_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
